// File: hw/rtl/sdg_pkg.sv
// Shared types and constants for the sidechain dynamics gain block.
// Used by sdg_mul, sidechain_dynamics_gain and the testbench; depends on nothing.
package sdg_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MUL_A_W     = 33;
  localparam int MUL_B_W     = 31;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  localparam logic [15:0] RMS_COEF    = 16'd65400;
  localparam logic [7:0]  RMS_IN_COEF = 8'd136;
  localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
  localparam logic [21:0] LOG2_PER_DB = 22'd2786635;
  localparam logic [14:0] DB_FLOOR    = 15'd25600;
  localparam logic [12:0] DUCK_SPAN   = 13'd6144;
  localparam logic [17:0] DUCK_RECIP  = 18'd174763;
  localparam logic [16:0] UNITY       = 17'd65536;

  localparam logic [2:0] CFG_MODE      = 3'd0;
  localparam logic [2:0] CFG_DETECTOR  = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_CURVE     = 3'd3;
  localparam logic [2:0] CFG_ATTACK    = 3'd4;
  localparam logic [2:0] CFG_RELEASE   = 3'd5;
  localparam logic [2:0] CFG_MAKEUP    = 3'd6;
  localparam logic [2:0] CFG_LOOKAHEAD = 3'd7;

  localparam logic [1:0] MODE_COMP   = 2'd0;
  localparam logic [1:0] MODE_GATE   = 2'd1;
  localparam logic [1:0] MODE_DUCK   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic       DET_PEAK    = 1'b0;
  localparam logic       DET_RMS     = 1'b1;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_op_t;

  // Q0.24 values of 2^(-2^-(k+1)).
  function automatic logic [23:0] exp_tab(input logic [3:0] k);
    logic [23:0] v;
    unique case (k)
      4'd0:  v = 24'd11863283;
      4'd1:  v = 24'd14107901;
      4'd2:  v = 24'd15384775;
      4'd3:  v = 24'd16065917;
      4'd4:  v = 24'd16417715;
      4'd5:  v = 24'd16596492;
      4'd6:  v = 24'd16686609;
      4'd7:  v = 24'd16731851;
      4'd8:  v = 24'd16754518;
      4'd9:  v = 24'd16765863;
      4'd10: v = 24'd16771539;
      4'd11: v = 24'd16774377;
      4'd12: v = 24'd16775796;
      4'd13: v = 24'd16776506;
      4'd14: v = 24'd16776861;
      4'd15: v = 24'd16777039;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/sdg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the lookahead delay ring.
module sdg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/sdg_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on sdg_pkg for the operand struct and widths.
module sdg_mul (
  input  logic                          clk,
  input  sdg_pkg::mul_op_t              op,
  output logic [sdg_pkg::MUL_P_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= sdg_pkg::MUL_P_W'(op.a) * sdg_pkg::MUL_P_W'(op.b);
  end

endmodule

// File: hw/rtl/sidechain_dynamics_gain.sv
// Sidechain compressor, gate and ducker with lookahead on the main path.
// Depends on sdg_pkg, sdg_mul (shared multiplier) and sdg_ram (delay ring).
//
// Usage: in_tdata carries one transaction of four Q1.15 samples; out_tdata
// returns both processed main samples and the current gain reduction.
// The cfg channel writes register cfg_index with cfg_data; cfg_ready is
// always high. Make writes only while the block is idle; the block does not enforce it.
// A sequencer runs every step through one multiplier, a shift-subtract
// square root and a squaring log2 loop. The two 16-step log2 loops and
// the 16-step exponent loop make up most of an item's work; an item is
// shortest in peak mode with the gate or ducker and longest in RMS
// compressor mode. in_tready is high only while the sequencer waits for a
// sample.
// After reset the delay ring is cleared, one row a cycle, over all
// LOOKAHEAD_MAX rows; in_tready stays low meanwhile.
// The result sits in an output register. A new item is accepted while it
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds in its last step until out_tready rises.
module sidechain_dynamics_gain #(
  parameter int LOOKAHEAD_MAX = 512,
  parameter int CHANNELS      = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: main_left[15:0], main_right[31:16], side_left[47:32], side_right[63:48]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // tdata: out_left[15:0], out_right[31:16], gain_reduction_db[46:32], zero[47]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW      = $clog2(LOOKAHEAD_MAX);
  localparam int RING_CH = (CHANNELS < 2) ? CHANNELS : 2;
  localparam int RW      = RING_CH * sdg_pkg::SAMPLE_BITS;
  localparam int LA_LIM  = LOOKAHEAD_MAX - 1;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_RMS0   = 5'd2;
  localparam logic [4:0] S_RMS1   = 5'd3;
  localparam logic [4:0] S_RMS2   = 5'd4;
  localparam logic [4:0] S_RMS3   = 5'd5;
  localparam logic [4:0] S_SQRT   = 5'd6;
  localparam logic [4:0] S_LOGN   = 5'd7;
  localparam logic [4:0] S_LSQ    = 5'd8;
  localparam logic [4:0] S_LST    = 5'd9;
  localparam logic [4:0] S_LDB    = 5'd10;
  localparam logic [4:0] S_LDB2   = 5'd11;
  localparam logic [4:0] S_DBDONE = 5'd12;
  localparam logic [4:0] S_TGT    = 5'd13;
  localparam logic [4:0] S_CMP1   = 5'd14;
  localparam logic [4:0] S_CMP2   = 5'd15;
  localparam logic [4:0] S_EXP    = 5'd16;
  localparam logic [4:0] S_EXP2   = 5'd17;
  localparam logic [4:0] S_EXPF   = 5'd18;
  localparam logic [4:0] S_DK1    = 5'd19;
  localparam logic [4:0] S_DK2    = 5'd20;
  localparam logic [4:0] S_SM     = 5'd21;
  localparam logic [4:0] S_SM2    = 5'd22;
  localparam logic [4:0] S_GM     = 5'd23;
  localparam logic [4:0] S_OL     = 5'd24;
  localparam logic [4:0] S_OR     = 5'd25;
  localparam logic [4:0] S_OR2    = 5'd26;
  localparam logic [4:0] S_FIN    = 5'd27;

  // Configuration registers.
  logic [1:0]  mode_r;
  logic        detector_r;
  logic [15:0] threshold_r;
  logic [16:0] curve_r;
  logic [15:0] attack_r, release_r, makeup_r;
  logic [8:0]  lookahead_r;

  // Sequencer state.
  logic [4:0]  state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [15:0] ml_r, ml_nxt, mr_r, mr_nxt;
  logic [15:0] mag_r, mag_nxt;
  logic [31:0] pw_r, pw_nxt;
  logic [38:0] tmp_r, tmp_nxt;
  logic [32:0] sv_r, sv_nxt, sq_r, sq_nxt;
  logic [31:0] sb_r, sb_nxt;
  logic [16:0] v_r, v_nxt;
  logic [30:0] x_r, x_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [4:0]  e_r, e_nxt;
  logic [14:0] db_r, db_nxt;
  logic        dbsel_r, dbsel_nxt;
  logic [16:0] tgt_r, tgt_nxt;
  logic [16:0] sg_r, sg_nxt;
  logic [4:0]  ip_r, ip_nxt;
  logic [15:0] f_r, f_nxt;
  logic [24:0] acc_r, acc_nxt;
  logic [32:0] gm_r, gm_nxt;
  logic [15:0] resl_r, resl_nxt, resr_r, resr_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  sdg_pkg::mul_op_t mop;
  logic [sdg_pkg::MUL_P_W-1:0] prod_r;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata_r;

  sdg_mul u_mul (
    .clk    (clk),
    .op     (mop),
    .prod_r (prod_r)
  );

  sdg_ram #(
    .WIDTH (RW),
    .DEPTH (LOOKAHEAD_MAX)
  ) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata_r)
  );

  // Saturating signed result from a rounded magnitude.
  function automatic logic [15:0] sat_out(input logic neg, input logic [20:0] m);
    logic [15:0] r;
    if (neg) begin
      r = (m >= 21'd32768) ? 16'h8000 : 16'(~m[15:0] + 16'd1);
    end else begin
      r = (m >= 21'd32767) ? 16'h7FFF : m[15:0];
    end
    return r;
  endfunction

  // Effective lookahead and ring addressing.
  logic [31:0]   la_ext, la_eff32;
  logic [AW-1:0] la_eff;
  logic          la_on;
  logic [AW:0]   rp_diff, rp_fix;

  always_comb begin
    la_ext   = {23'd0, lookahead_r};
    la_eff32 = (la_ext > 32'(LA_LIM)) ? 32'(LA_LIM) : la_ext;
    la_eff   = la_eff32[AW-1:0];
    la_on    = (la_eff32 != 32'd0);
    rp_diff  = {1'b0, wp_r} - {1'b0, la_eff};
    rp_fix   = rp_diff[AW] ? (rp_diff + (AW+1)'(LOOKAHEAD_MAX)) : rp_diff;
  end

  // Sidechain mono magnitude.
  logic signed [16:0] side_sum;
  logic signed [16:0] mono;
  logic [16:0]        mono_abs;

  always_comb begin
    side_sum = 17'(signed'(in_tdata[47:32])) + 17'(signed'(in_tdata[63:48]));
    mono     = side_sum >>> 1;
    mono_abs = mono[16] ? 17'(-mono) : 17'(mono);
  end

  // Main samples after the optional delay.
  logic [15:0] s_left, s_right, abs_left, abs_right;

  always_comb begin
    s_left    = la_on ? ram_rdata_r[15:0] : ml_r;
    s_right   = (la_on && CHANNELS > 1) ? ram_rdata_r[RW-1 -: 16] : mr_r;
    abs_left  = s_left[15] ? 16'(-s_left) : s_left;
    abs_right = s_right[15] ? 16'(-s_right) : s_right;
    for (int c = 0; c < RING_CH; c++) begin
      ram_wdata[c*16 +: 16] = (state_r == S_CLR) ? 16'd0 : ((c == 0) ? ml_r : mr_r);
    end
  end

  logic in_fire, out_fire, fin_go;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ram_re    = in_fire;
  assign ram_raddr = rp_fix[AW-1:0];
  assign ram_we    = (state_r == S_CLR) || (fin_go && la_on);
  assign ram_waddr = (state_r == S_CLR) ? clr_r : wp_r;

  // Datapath helpers.
  logic [33:0] sq_sum;
  logic [20:0] l_val, full_val;
  logic [31:0] ly;
  logic [4:0]  lead;
  logic signed [16:0] ctrl_s, thr_s;
  logic signed [17:0] over_s;
  logic [16:0] over_u, amt, duck_over;
  logic [33:0] gr_sum;
  logic [39:0] t_sum;
  logic [29:0] dk_x;
  logic [48:0] exp_sum;
  logic [5:0]  sh;
  logic [31:0] shr_sum;
  logic [40:0] db_sum;
  logic [16:0] db_mag;
  logic [48:0] out_sum;
  logic [47:0] rms_sum;
  logic [16:0] sm_diff, sm_dmag;
  logic        sm_down;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    wp_nxt        = wp_r;
    ml_nxt        = ml_r;
    mr_nxt        = mr_r;
    mag_nxt       = mag_r;
    pw_nxt        = pw_r;
    tmp_nxt       = tmp_r;
    sv_nxt        = sv_r;
    sq_nxt        = sq_r;
    sb_nxt        = sb_r;
    v_nxt         = v_r;
    x_nxt         = x_r;
    frac_nxt      = frac_r;
    e_nxt         = e_r;
    db_nxt        = db_r;
    dbsel_nxt     = dbsel_r;
    tgt_nxt       = tgt_r;
    sg_nxt        = sg_r;
    ip_nxt        = ip_r;
    f_nxt         = f_r;
    acc_nxt       = acc_r;
    gm_nxt        = gm_r;
    resl_nxt      = resl_r;
    resr_nxt      = resr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    mop           = '0;

    sq_sum   = {1'b0, sq_r} + {2'b0, sb_r};
    ly       = prod_r[61:30];
    l_val    = {e_r, frac_r};
    full_val = dbsel_r ? {5'd16, 16'd0} : {5'd15, 16'd0};
    lead     = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (v_r[i]) begin
        lead = 5'(i);
      end
    end
    ctrl_s    = -signed'({2'b0, db_r});
    thr_s     = 17'(signed'(threshold_r));
    over_s    = 18'(ctrl_s) - 18'(thr_s);
    over_u    = over_s[16:0];
    amt       = (curve_r > sdg_pkg::UNITY) ? sdg_pkg::UNITY : curve_r;
    duck_over = (over_u > 17'(sdg_pkg::DUCK_SPAN)) ? 17'(sdg_pkg::DUCK_SPAN) : over_u;
    gr_sum    = prod_r[33:0] + 34'd32768;
    t_sum     = prod_r[39:0] + 40'd32768;
    dk_x      = prod_r[29:0] + 30'(sdg_pkg::DUCK_SPAN / 2);
    exp_sum   = prod_r[48:0] + (49'd1 << 23);
    sh        = 6'd8 + {1'b0, ip_r};
    shr_sum   = {7'd0, acc_r} + (32'd1 << (sh - 6'd1));
    db_sum    = prod_r[40:0] + (41'd1 << 23);
    db_mag    = db_sum[40:24];
    out_sum   = prod_r[48:0] + (49'd1 << 27);
    rms_sum   = prod_r[47:0] + {9'd0, tmp_r};
    sm_down   = (sg_r >= tgt_r);
    sm_diff   = sm_down ? (sg_r - tgt_r) : (tgt_r - sg_r);
    sm_dmag   = prod_r[32:16];

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(LA_LIM)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          ml_nxt  = in_tdata[15:0];
          mr_nxt  = in_tdata[31:16];
          mag_nxt = mono_abs[15:0];
          dbsel_nxt = 1'b0;
          if (detector_r == sdg_pkg::DET_RMS) begin
            state_nxt = S_RMS0;
          end else begin
            v_nxt     = mono_abs;
            state_nxt = S_LOGN;
          end
        end
      end
      S_RMS0: begin
        mop.a     = 33'(mag_r);
        mop.b     = 31'(mag_r);
        state_nxt = S_RMS1;
      end
      S_RMS1: begin
        mop.a     = {2'b0, prod_r[30:0]};
        mop.b     = 31'(sdg_pkg::RMS_IN_COEF);
        state_nxt = S_RMS2;
      end
      S_RMS2: begin
        tmp_nxt   = prod_r[38:0];
        mop.a     = 33'(pw_r);
        mop.b     = 31'(sdg_pkg::RMS_COEF);
        state_nxt = S_RMS3;
      end
      S_RMS3: begin
        pw_nxt    = rms_sum[47:16];
        sv_nxt    = {1'b0, rms_sum[47:16]};
        sq_nxt    = '0;
        sb_nxt    = 32'h4000_0000;
        cnt_nxt   = 4'd0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        // One bit pair of the restoring square root per cycle.
        if ({1'b0, sv_r} >= sq_sum) begin
          sv_nxt = 33'({1'b0, sv_r} - sq_sum);
          sq_nxt = (sq_r >> 1) + 33'(sb_r);
        end else begin
          sq_nxt = sq_r >> 1;
        end
        sb_nxt  = sb_r >> 2;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          v_nxt     = sq_nxt[16:0];
          state_nxt = S_LOGN;
        end
      end
      S_LOGN: begin
        if (v_r == 17'd0) begin
          db_nxt    = sdg_pkg::DB_FLOOR;
          state_nxt = S_DBDONE;
        end else begin
          e_nxt     = lead;
          x_nxt     = {14'd0, v_r} << (5'd30 - lead);
          frac_nxt  = '0;
          cnt_nxt   = 4'd0;
          state_nxt = S_LSQ;
        end
      end
      S_LSQ: begin
        mop.a     = 33'(x_r);
        mop.b     = x_r;
        state_nxt = S_LST;
      end
      S_LST: begin
        frac_nxt = {frac_r[14:0], ly[31]};
        x_nxt    = ly[31] ? ly[31:1] : ly[30:0];
        cnt_nxt  = cnt_r + 4'd1;
        state_nxt = (cnt_r == 4'd15) ? S_LDB : S_LSQ;
      end
      S_LDB: begin
        if (l_val >= full_val) begin
          db_nxt    = 15'd0;
          state_nxt = S_DBDONE;
        end else begin
          mop.a     = 33'(full_val - l_val);
          mop.b     = 31'(sdg_pkg::DB_PER_LOG2);
          state_nxt = S_LDB2;
        end
      end
      S_LDB2: begin
        db_nxt    = (db_mag > 17'(sdg_pkg::DB_FLOOR)) ? sdg_pkg::DB_FLOOR : db_mag[14:0];
        state_nxt = S_DBDONE;
      end
      S_DBDONE: begin
        state_nxt = dbsel_r ? S_FIN : S_TGT;
      end
      S_TGT: begin
        if (mode_r == sdg_pkg::MODE_GATE) begin
          tgt_nxt   = (ctrl_s > thr_s) ? sdg_pkg::UNITY : 17'd0;
          state_nxt = S_SM;
        end else if (mode_r == sdg_pkg::MODE_UNUSED || ctrl_s <= thr_s) begin
          tgt_nxt   = sdg_pkg::UNITY;
          state_nxt = S_SM;
        end else if (mode_r == sdg_pkg::MODE_COMP) begin
          mop.a     = 33'(over_u);
          mop.b     = 31'(amt);
          state_nxt = S_CMP1;
        end else begin
          mop.a     = 33'(amt);
          mop.b     = 31'(duck_over);
          state_nxt = S_DK1;
        end
      end
      S_CMP1: begin
        mop.a     = 33'(gr_sum[33:16]);
        mop.b     = 31'(sdg_pkg::LOG2_PER_DB);
        state_nxt = S_CMP2;
      end
      S_CMP2: begin
        ip_nxt    = t_sum[36:32];
        f_nxt     = t_sum[31:16];
        acc_nxt   = 25'd1 << 24;
        cnt_nxt   = 4'd0;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        mop.a     = 33'(acc_r);
        mop.b     = 31'(sdg_pkg::exp_tab(cnt_r));
        state_nxt = S_EXP2;
      end
      S_EXP2: begin
        if (f_r[4'd15 - cnt_r]) begin
          acc_nxt = exp_sum[48:24];
        end
        cnt_nxt   = cnt_r + 4'd1;
        state_nxt = (cnt_r == 4'd15) ? S_EXPF : S_EXP;
      end
      S_EXPF: begin
        tgt_nxt   = 17'(shr_sum >> sh);
        state_nxt = S_SM;
      end
      S_DK1: begin
        mop.a     = 33'(dk_x[29:11]);
        mop.b     = 31'(sdg_pkg::DUCK_RECIP);
        state_nxt = S_DK2;
      end
      S_DK2: begin
        tgt_nxt   = sdg_pkg::UNITY - prod_r[35:19];
        state_nxt = S_SM;
      end
      S_SM: begin
        mop.a     = 33'(sm_diff);
        mop.b     = 31'((tgt_r < sg_r) ? attack_r : release_r);
        state_nxt = S_SM2;
      end
      S_SM2: begin
        sg_nxt    = sm_down ? (tgt_r + sm_dmag) : (tgt_r - sm_dmag);
        state_nxt = S_GM;
      end
      S_GM: begin
        mop.a     = 33'(sg_r);
        mop.b     = 31'(makeup_r);
        state_nxt = S_OL;
      end
      S_OL: begin
        gm_nxt    = prod_r[32:0];
        mop.a     = prod_r[32:0];
        mop.b     = 31'(abs_left);
        state_nxt = S_OR;
      end
      S_OR: begin
        resl_nxt  = sat_out(s_left[15], out_sum[48:28]);
        mop.a     = gm_r;
        mop.b     = 31'(abs_right);
        state_nxt = S_OR2;
      end
      S_OR2: begin
        resr_nxt  = sat_out(s_right[15], out_sum[48:28]);
        v_nxt     = sg_r;
        dbsel_nxt = 1'b1;
        state_nxt = S_LOGN;
      end
      S_FIN: begin
        if (fin_go) begin
          out_data_nxt  = {1'b0, db_r, resr_r, resl_r};
          out_valid_nxt = 1'b1;
          if (la_on) begin
            wp_nxt = (wp_r == AW'(LA_LIM)) ? AW'(0) : wp_r + AW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      wp_r        <= '0;
      pw_r        <= '0;
      sg_r        <= sdg_pkg::UNITY;
      dbsel_r     <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= sdg_pkg::MODE_COMP;
      detector_r  <= sdg_pkg::DET_PEAK;
      threshold_r <= 16'hEC00;
      curve_r     <= 17'd49152;
      attack_r    <= 16'd64000;
      release_r   <= 16'd65400;
      makeup_r    <= 16'd4096;
      lookahead_r <= 9'd0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      wp_r        <= wp_nxt;
      pw_r        <= pw_nxt;
      sg_r        <= sg_nxt;
      dbsel_r     <= dbsel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index[7:3] == 5'd0) begin
          unique case (cfg_index[2:0])
            sdg_pkg::CFG_MODE:      mode_r      <= cfg_data[1:0];
            sdg_pkg::CFG_DETECTOR:  detector_r  <= cfg_data[0];
            sdg_pkg::CFG_THRESHOLD: threshold_r <= cfg_data[15:0];
            sdg_pkg::CFG_CURVE:     curve_r     <= cfg_data[16:0];
            sdg_pkg::CFG_ATTACK:    attack_r    <= cfg_data[15:0];
            sdg_pkg::CFG_RELEASE:   release_r   <= cfg_data[15:0];
            sdg_pkg::CFG_MAKEUP:    makeup_r    <= cfg_data[15:0];
            sdg_pkg::CFG_LOOKAHEAD: lookahead_r <= cfg_data[8:0];
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ml_r       <= ml_nxt;
    mr_r       <= mr_nxt;
    mag_r      <= mag_nxt;
    tmp_r      <= tmp_nxt;
    sv_r       <= sv_nxt;
    sq_r       <= sq_nxt;
    sb_r       <= sb_nxt;
    v_r        <= v_nxt;
    x_r        <= x_nxt;
    frac_r     <= frac_nxt;
    e_r        <= e_nxt;
    db_r       <= db_nxt;
    tgt_r      <= tgt_nxt;
    ip_r       <= ip_nxt;
    f_r        <= f_nxt;
    acc_r      <= acc_nxt;
    gm_r       <= gm_nxt;
    resl_r     <= resl_nxt;
    resr_r     <= resr_nxt;
    out_data_r <= out_data_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while an item is still in work");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    sg_r <= sdg_pkg::UNITY)
    else $error("smoothed gain above unity");

  a_ring_ports: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ring written and read at one address");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result shown outside the final step");

endmodule

// File: test/sidechain_dynamics_gain_tb.sv
// Self-checking testbench for the sidechain dynamics gain block.
// Depends on sdg_pkg and the sidechain_dynamics_gain RTL; a scoreboard predicts every result.
`timescale 1ns / 100ps

module sidechain_dynamics_gain_tb;

  localparam int          RING_LEN   = 512;
  localparam int          IDLE_LIMIT = 20000;
  localparam logic [7:0]  CFG_NONE   = 8'd9;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [14:0] reduction;
  } gain_result_t;

  class gain_scoreboard;
    int unsigned mode, detector, curve, attack, rel_coef, makeup, lookahead;
    int          threshold;
    longint unsigned power;
    int unsigned gain;
    logic [15:0] ring [2][RING_LEN];
    int unsigned wpos;
    gain_result_t expected_q[$];
    int errors;
    int unsigned pow_tab[16] = '{
      11863283, 14107901, 15384775, 16065917, 16417715, 16596492,
      16686609, 16731851, 16754518, 16765863, 16771539, 16774377,
      16775796, 16776506, 16776861, 16777039};

    function new();
      mode = 0; detector = 0; threshold = -5120; curve = 49152;
      attack = 64000; rel_coef = 65400; makeup = 4096; lookahead = 0;
      power = 0; gain = 65536; wpos = 0; errors = 0;
      foreach (ring[c, i]) ring[c][i] = '0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [31:0] data);
      case (idx)
        {5'd0, sdg_pkg::CFG_MODE}:      mode = data[1:0];
        {5'd0, sdg_pkg::CFG_DETECTOR}:  detector = data[0];
        {5'd0, sdg_pkg::CFG_THRESHOLD}: threshold = $signed(data[15:0]);
        {5'd0, sdg_pkg::CFG_CURVE}:     curve = data[16:0];
        {5'd0, sdg_pkg::CFG_ATTACK}:    attack = data[15:0];
        {5'd0, sdg_pkg::CFG_RELEASE}:   rel_coef = data[15:0];
        {5'd0, sdg_pkg::CFG_MAKEUP}:    makeup = data[15:0];
        {5'd0, sdg_pkg::CFG_LOOKAHEAD}: lookahead = data[8:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function int unsigned log2_fix(int unsigned v);
      int unsigned e, frac;
      longint unsigned x;
      e = 0;
      frac = 0;
      while ((v >> (e + 1)) != 0 && e < 30) e++;
      x = longint'(v) << (30 - e);
      for (int i = 0; i < 16; i++) begin
        x = (x * x) >> 30;
        frac <<= 1;
        if (x >= (64'd1 << 31)) begin
          x >>= 1;
          frac |= 1;
        end
      end
      return (e << 16) + frac;
    endfunction

    // Attenuation below full scale in Q7.8, saturating at the 100 dB floor.
    function int unsigned atten_db(int unsigned v, int unsigned fbits);
      int unsigned l, full;
      longint unsigned mag;
      full = fbits << 16;
      if (v == 0) return 25600;
      l = log2_fix(v);
      if (l >= full) return 0;
      mag = (longint'(full - l) * 394566 + (64'd1 << 23)) >> 24;
      return mag > 25600 ? 25600 : 32'(mag);
    endfunction

    function int unsigned linear_gain(int unsigned gr);
      longint unsigned t, ip, acc;
      int unsigned f, sh;
      t = (longint'(gr) * 2786635 + 32768) >> 16;
      ip = t >> 16;
      acc = 64'd1 << 24;
      f = 32'(t & 64'hFFFF);
      for (int k = 0; k < 16; k++)
        if ((f >> (15 - k)) & 1) acc = (acc * pow_tab[k] + (64'd1 << 23)) >> 24;
      if (ip > 40) return 0;
      sh = 8 + 32'(ip);
      return 32'((acc + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function int unsigned gain_target(int level_db);
      int unsigned amt, over;
      amt = curve > 65536 ? 65536 : curve;
      if (mode == sdg_pkg::MODE_GATE) return level_db > threshold ? 65536 : 0;
      if (mode > sdg_pkg::MODE_DUCK || level_db <= threshold) return 65536;
      over = level_db - threshold;
      if (mode == sdg_pkg::MODE_COMP)
        return linear_gain(32'((longint'(over) * amt + 32768) >> 16));
      if (over > 6144) over = 6144;
      return 65536 - 32'((longint'(amt) * over + 3072) / 6144);
    endfunction

    function void note_input(logic [63:0] d);
      int sum, mono, level_db;
      int unsigned mag, level, tgt, coef, la, wp, rp;
      longint unsigned gm, m;
      longint s;
      logic [15:0] smp;
      gain_result_t res;
      sum = int'($signed(d[47:32])) + int'($signed(d[63:48]));
      mono = sum >= 0 ? sum / 2 : -((-sum + 1) / 2);
      mag = mono < 0 ? -mono : mono;
      if (detector == sdg_pkg::DET_RMS) begin
        power = (65400 * power + 136 * longint'(mag) * mag) >> 16;
        level = 32'(root(power));
      end else begin
        level = mag;
      end
      level_db = -int'(atten_db(level, 15));
      tgt = gain_target(level_db);
      coef = tgt < gain ? attack : rel_coef;
      if (gain >= tgt) gain = tgt + 32'((longint'(gain - tgt) * coef) >> 16);
      else gain = tgt - 32'((longint'(tgt - gain) * coef) >> 16);
      gm = longint'(gain) * makeup;
      la = lookahead > RING_LEN - 1 ? RING_LEN - 1 : lookahead;
      wp = wpos % RING_LEN;
      rp = (wp + RING_LEN - la) % RING_LEN;
      for (int ch = 0; ch < 2; ch++) begin
        smp = ch == 0 ? d[15:0] : d[31:16];
        if (la > 0) begin
          ring[ch][wp] = smp;
          smp = ring[ch][rp];
          if (rp == wp) smp = ch == 0 ? d[15:0] : d[31:16];
        end
        s = $signed(smp);
        m = s < 0 ? -s : s;
        m = (m * gm + (64'd1 << 27)) >> 28;
        if (m > 32768) m = 32768;
        s = s < 0 ? -longint'(m) : longint'(m);
        if (s > 32767) s = 32767;
        if (ch == 0) res.left = s[15:0];
        else res.right = s[15:0];
      end
      if (la > 0) wpos = (wpos + 1) % RING_LEN;
      res.reduction = 15'(atten_db(gain, 16));
      expected_q.push_back(res);
    endfunction

    function void check(logic [47:0] d);
      gain_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction %h", d);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (d[15:0] !== e.left) begin
        $error("out_left expected %0d actual %0d", $signed(e.left), $signed(d[15:0]));
        errors++;
      end
      if (d[31:16] !== e.right) begin
        $error("out_right expected %0d actual %0d", $signed(e.right), $signed(d[31:16]));
        errors++;
      end
      if (d[46:32] !== e.reduction) begin
        $error("gain_reduction_db expected %0d actual %0d", e.reduction, d[46:32]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  gain_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  sidechain_dynamics_gain dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
    if (rst_n && cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sidechain_dynamics_gain test failed");
      $finish;
    end
  end

  // Valid stays high across back-to-back transactions; it only drops for a gap.
  task automatic send_frame(logic signed [15:0] ml, mr, sl, sr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sr, sl, mr, ml};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (sb.expected_q.size() == 0);
    repeat (160) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(int md, int det, int thr, int crv, int att, int rel, int mk, int la);
    write_reg(sdg_pkg::CFG_MODE, md);
    write_reg(sdg_pkg::CFG_DETECTOR, det);
    write_reg(sdg_pkg::CFG_THRESHOLD, thr);
    write_reg(sdg_pkg::CFG_CURVE, crv);
    write_reg(sdg_pkg::CFG_ATTACK, att);
    write_reg(sdg_pkg::CFG_RELEASE, rel);
    write_reg(sdg_pkg::CFG_MAKEUP, mk);
    write_reg(sdg_pkg::CFG_LOOKAHEAD, la);
    end_writes();
  endtask

  function automatic logic [15:0] rand_sample(int shift);
    logic signed [15:0] v;
    v = 16'($urandom);
    return v >>> shift;
  endfunction

  task automatic random_phase(int count);
    int shift;
    shift = $urandom_range(15);
    for (int i = 0; i < count; i++) begin
      // The level drifts in bursts so attack, release and gating all get exercised.
      if ($urandom_range(29) == 0) shift = $urandom_range(15);
      send_frame(rand_sample($urandom_range(3) == 0 ? 0 : shift),
                 rand_sample($urandom_range(3) == 0 ? 0 : shift),
                 rand_sample(shift), rand_sample(shift));
    end
  endtask

  function automatic int pick_coef();
    case ($urandom_range(5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(60000, 65535);
      default: return $urandom_range(65535);
    endcase
  endfunction

  initial begin
    int thr;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reset defaults, sample extremes, every mode and detector.
    send_frame(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_frame(16'sh0000, 16'shFFFF, 16'sh0000, 16'sh0000);
    send_frame(16'sh1234, 16'sh8000, 16'sh0001, 16'shFFFE);
    drain();
    setup(sdg_pkg::MODE_GATE, sdg_pkg::DET_RMS, -25600, 65536, 0, 65535, 65535, 3);
    send_frame(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh4000, 16'shC000, 16'sh0000, 16'sh0000);
    send_frame(16'sh0100, 16'sh0200, 16'sh0001, 16'sh0000);
    send_frame(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
    drain();
    // Duck with an oversized curve amount and a lookahead change without flush.
    setup(sdg_pkg::MODE_DUCK, sdg_pkg::DET_PEAK, -12000, 131071, 65535, 0, 0, 511);
    send_frame(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000);
    send_frame(16'sh0001, 16'shFFFF, 16'sh0100, 16'sh0100);
    drain();
    write_reg(sdg_pkg::CFG_MAKEUP, 65535);
    write_reg(sdg_pkg::CFG_LOOKAHEAD, 1);
    end_writes();
    send_frame(16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    drain();
    // Unused mode, a zero threshold, and a write to an unmapped index.
    setup(sdg_pkg::MODE_UNUSED, sdg_pkg::DET_RMS, 0, 0, 32768, 32768, 4096, 0);
    write_reg(CFG_NONE, 32'hFFFF_FFFF);
    end_writes();
    send_frame(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh1000, 16'sh2000, 16'sh0000, 16'sh0000);
    drain();
    setup(sdg_pkg::MODE_COMP, sdg_pkg::DET_PEAK, 16'sh7FFF, 65536, 64000, 65400, 4096, 0);
    send_frame(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    drain();
    setup(sdg_pkg::MODE_COMP, sdg_pkg::DET_PEAK, -32768, 65536, 0, 0, 8192, 2);
    send_frame(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh4000, 16'shC000, 16'sh0010, 16'sh0010);
    send_frame(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      thr = $urandom_range(7) == 0 ? int'($signed(16'($urandom))) : -$urandom_range(25600);
      setup(p < 4 ? p : $urandom_range(3), $urandom_range(1), thr,
            $urandom_range(7) == 0 ? $urandom_range(131071) : $urandom_range(65536),
            pick_coef(), pick_coef(), $urandom_range(65535),
            $urandom_range(3) == 0 ? $urandom_range(511) : $urandom_range(8));
      random_phase(210);
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("sidechain_dynamics_gain test passed");
    else
      $display("sidechain_dynamics_gain test failed");
    $finish;
  end

endmodule
